// ----- design/cpa_pkg.sv -----
// Shared constants, types and codes of the contiguous page allocator.
package cpa_pkg;

    // Sizing of the page region
    localparam int MAX_PAGES  = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_OFS_W = $clog2(PAGE_BYTES);
    localparam int IDX_W      = $clog2(MAX_PAGES);

    // Field widths
    localparam int ADDR_W = 56;
    localparam int CNT_W  = 11;
    localparam int DESC_W = 2;

    // Descriptor bits
    localparam int DESC_FREE_BIT = 0;
    localparam int DESC_LAST_BIT = 1;
    localparam logic [DESC_W-1:0] DESC_FREE = 2'b01;
    localparam logic [DESC_W-1:0] DESC_LAST = 2'b10;
    localparam logic [DESC_W-1:0] DESC_USED = 2'b00;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_REGION_BASE  = 1'b0;
    localparam logic CFG_PAGES_IN_USE = 1'b1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [DESC_W-1:0] desc_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ZERO    = 3'd1,
        ST_NOROOM  = 3'd2,
        ST_OUTSIDE = 3'd3,
        ST_ALREADY = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_SCAN,
        S_A_MARK,
        S_F_SUB,
        S_F_RANGE,
        S_F_READ,
        S_F_WRITE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] region_base;
        logic [CNT_W-1:0]  pages_in_use;
    } cfg_t;

    typedef struct packed {
        logic  we;
        idx_t  waddr;
        desc_t wdata;
        idx_t  raddr;
    } ram_req_t;

endpackage

// ----- design/cpa_if.sv -----
// Request and response channel interfaces of the page allocator.
interface cpa_req_if;
    import cpa_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [CNT_W-1:0]  page_count;
    logic [ADDR_W-1:0] address;

    modport source (output valid, kind, page_count, address, input ready);
    modport sink   (input valid, kind, page_count, address, output ready);
endinterface

interface cpa_rsp_if;
    import cpa_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] block_address;
    status_t           status;

    modport source (output valid, block_address, status, input ready);
    modport sink   (input valid, block_address, status, output ready);
endinterface

// ----- design/contiguous_page_allocator.sv -----
// Top level of the first-fit contiguous page allocator.
//
// Channel   Dir  Payload                         Handshake
// req       in   kind, page_count, address       valid/ready
// rsp       out  block_address, status           valid/ready
// cfg       in   cfg_index, cfg_data             cfg_we, no wait
//
// An allocate scans the descriptors for a first-fit run of free pages,
// then marks each page of the run used, then posts the result.
// A free runs a subtract and a range check, then a read and a write per page.
// Both loops go through the single read and write port of the descriptor RAM.
// After reset a clearing pass sets all MAX_PAGES (1024) descriptors free;
// req is not ready during it, cfg writes are taken at any time.
// The result waits in an output register, so a stalled rsp only holds the
// sequencer in its post step.
module contiguous_page_allocator (
    input  logic                      clk,
    input  logic                      rst_n,
    cpa_req_if.sink                   req,
    cpa_rsp_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [cpa_pkg::ADDR_W-1:0] cfg_data
);
    import cpa_pkg::*;

    logic [ADDR_W-1:0] region_base_reg;
    logic [CNT_W-1:0]  pages_in_use_reg;
    cfg_t              cfg;
    ram_req_t          ram_req;
    desc_t             ram_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg  <= '0;
            pages_in_use_reg <= CNT_W'(1024);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REGION_BASE:  region_base_reg  <= cfg_data;
                CFG_PAGES_IN_USE: pages_in_use_reg <= cfg_data[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.region_base  = region_base_reg;
    assign cfg.pages_in_use = pages_in_use_reg;

    cpa_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .rsp       (rsp),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    cpa_ram #(
        .WIDTH (DESC_W),
        .DEPTH (MAX_PAGES)
    ) u_desc_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

// ----- design/cpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cpa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- design/cpa_core.sv -----
// Sequencer and datapath that scans, marks and frees page descriptors.
module cpa_core (
    input  logic              clk,
    input  logic              rst_n,
    input  cpa_pkg::cfg_t     cfg,
    cpa_req_if.sink           req,
    cpa_rsp_if.source         rsp,
    output cpa_pkg::ram_req_t ram_req,
    input  cpa_pkg::desc_t    ram_rdata
);
    import cpa_pkg::*;

    state_t state_reg, state_next;

    idx_t              idx_reg, idx_next;
    idx_t              scan_reg, scan_next;
    idx_t              chk_idx_reg, chk_idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    idx_t              start_reg, start_next;
    idx_t              end_reg, end_next;
    logic [CNT_W-1:0]  want_reg, want_next;
    logic              first_reg, first_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W:0]   diff_reg, diff_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    status_t           res_status_reg, res_status_next;

    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    status_t           out_status_reg, out_status_next;

    logic [CNT_W-1:0]  eff_pages;
    logic [ADDR_W:0]   limit;
    logic              accept;
    logic              out_free;
    logic              chk_free;
    logic              chk_end;
    logic              run_hit;
    idx_t              start_sel;

    // Effective page count and byte limit of the region
    assign eff_pages = (cfg.pages_in_use > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                              : cfg.pages_in_use;
    assign limit     = (ADDR_W+1)'(eff_pages) << PAGE_OFS_W;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Scan check of the descriptor read in the previous cycle
    assign chk_free  = chk_vld_reg && ram_rdata[DESC_FREE_BIT];
    assign chk_end   = chk_vld_reg && (CNT_W'(chk_idx_reg) == eff_pages - CNT_W'(1));
    assign run_hit   = chk_free && ((run_reg + CNT_W'(1)) == want_reg);
    assign start_sel = (run_reg == '0) ? chk_idx_reg : start_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (idx_reg == idx_t'(MAX_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == KIND_FREE)
                    begin
                        state_next = S_F_SUB;
                    end
                    else if (req.page_count == '0 || req.page_count > eff_pages)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_A_SCAN;
                    end
                end
            end
            S_A_SCAN:
            begin
                if (run_hit)
                begin
                    state_next = S_A_MARK;
                end
                else if (chk_end)
                begin
                    state_next = S_RESP;
                end
            end
            S_A_MARK:
            begin
                if (idx_reg == end_reg)
                begin
                    state_next = S_RESP;
                end
            end
            S_F_SUB:
            begin
                state_next = S_F_RANGE;
            end
            S_F_RANGE:
            begin
                if (diff_reg[ADDR_W] || diff_reg >= limit)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_F_READ;
                end
            end
            S_F_READ:
            begin
                state_next = S_F_WRITE;
            end
            S_F_WRITE:
            begin
                if ((first_reg && ram_rdata[DESC_FREE_BIT]) || ram_rdata[DESC_LAST_BIT]
                    || idx_reg == idx_t'(MAX_PAGES - 1))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_F_READ;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        idx_next        = idx_reg;
        scan_next       = scan_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = chk_vld_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        want_next       = want_reg;
        first_next      = first_reg;
        addr_next       = addr_reg;
        diff_next       = diff_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = idx_reg;
        ram_req.wdata = DESC_FREE;
        ram_req.raddr = (state_reg == S_A_SCAN) ? scan_reg : idx_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep every descriptor to free after reset
                ram_req.we = 1'b1;
                idx_next   = idx_reg + idx_t'(1);
            end
            S_IDLE:
            begin
                res_addr_next = '0;
                want_next     = req.page_count;
                addr_next     = req.address;
                scan_next     = '0;
                chk_vld_next  = 1'b0;
                run_next      = '0;
                if (req.page_count == '0)
                begin
                    res_status_next = ST_ZERO;
                end
                else
                begin
                    res_status_next = ST_NOROOM;
                end
            end
            S_A_SCAN:
            begin
                // Issue the next read and count the run of free pages
                scan_next    = scan_reg + idx_t'(1);
                chk_idx_next = scan_reg;
                chk_vld_next = 1'b1;
                if (chk_free)
                begin
                    run_next   = run_reg + CNT_W'(1);
                    start_next = start_sel;
                end
                else if (chk_vld_reg)
                begin
                    run_next = '0;
                end
                if (run_hit)
                begin
                    idx_next        = start_sel;
                    end_next        = chk_idx_reg;
                    res_addr_next   = cfg.region_base
                                    + (ADDR_W'(start_sel) << PAGE_OFS_W);
                    res_status_next = ST_OK;
                end
                else if (chk_end)
                begin
                    res_status_next = ST_NOROOM;
                end
            end
            S_A_MARK:
            begin
                // Mark the run used, flag its last page
                ram_req.we    = 1'b1;
                ram_req.wdata = (idx_reg == end_reg) ? DESC_LAST : DESC_USED;
                idx_next      = idx_reg + idx_t'(1);
            end
            S_F_SUB:
            begin
                diff_next = {1'b0, addr_reg} - {1'b0, cfg.region_base};
            end
            S_F_RANGE:
            begin
                res_status_next = ST_OUTSIDE;
                idx_next        = diff_reg[PAGE_OFS_W +: IDX_W];
                first_next      = 1'b1;
            end
            S_F_READ:
            begin
                // Read issued at idx_reg
            end
            S_F_WRITE:
            begin
                first_next = 1'b0;
                if (first_reg && ram_rdata[DESC_FREE_BIT])
                begin
                    res_status_next = ST_ALREADY;
                end
                else
                begin
                    ram_req.we      = 1'b1;
                    res_status_next = ST_OK;
                    idx_next        = idx_reg + idx_t'(1);
                end
            end
            S_RESP:
            begin
                // Wait for the output slot
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_RESP && out_free)
        begin
            out_valid_next  = 1'b1;
            out_addr_next   = res_addr_reg;
            out_status_next = res_status_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.block_address = out_addr_reg;
    assign rsp.status        = out_status_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            chk_vld_reg   <= chk_vld_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        chk_idx_reg    <= chk_idx_next;
        run_reg        <= run_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        want_reg       <= want_next;
        addr_reg       <= addr_next;
        diff_reg       <= diff_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

endmodule
